[sv/rwlf_pkg.sv]
package rwlf_pkg;

  // Number of clients served by the lock; one queue slot per client.
  localparam int CLIENTS = 16;
  localparam int IDX_W   = $clog2(CLIENTS);
  localparam int CNT_W   = $clog2(CLIENTS + 1);
  localparam int HOLD_W  = 8;
  localparam int TOT_W   = 12;

  typedef logic [3:0] client_t;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_ABORT   = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    KIND_OK    = 2'd0,
    KIND_GRANT = 2'd1,
    KIND_DENY  = 2'd2,
    KIND_BUSY  = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_code_t command;
    client_t   client;
    logic      allowed;
  } in_item_t;

  typedef struct packed {
    kind_t   kind;
    client_t target;
    logic    exclusive;
    logic    last;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    DP_NONE    = 3'd0,
    DP_CAPTURE = 3'd1,
    DP_REPLY   = 3'd2,
    DP_ENQUEUE = 3'd3,
    DP_RELEASE = 3'd4,
    DP_FIND    = 3'd5,
    DP_DROP    = 3'd6,
    DP_GRANT   = 3'd7
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    kind_t  kind;
    logic   last;
    logic   run_sel;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_code_t command;
    logic      allowed;
    logic      in_range;
    logic      pending;
    logic      holds_zero;
    logic      queue_full;
    logic      release_rerun;
    logic      can_grant;
    logic      grant_more;
    logic      out_free;
  } dp_status_t;

endpackage

[sv/reader_writer_lock_fifo.sv]
// Sequence: a request is taken in S_IDLE and decided in S_EXEC; a request with no result
// (queued behind a holder) then passes S_RUN, an abort of a queued client passes S_DROP,
// and a request or release that grants runs S_RUN, which grants from the queue head.
// Throughput: one request at a time; one grant per cycle while the output register is free.
// Reset: synchronous, active-low rst_n clears the controller, the queue count, the hold
// totals, the pending flags and the output valid flag; queue entries are not reset.
module reader_writer_lock_fifo import rwlf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // The controller sequences each request through decode, an optional grant loop and
  // an optional abort step. The datapath holds the waiting queue, the per-client pending
  // flags and hold counters, the global hold total and the output register.
  ctl_cmd_t   cmd;
  dp_status_t st;

  rwlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Results land in a single output register; the controller only issues a result
  // when that register is empty or being drained in the same cycle.
  rwlf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_ready (out_ready),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // A result is never written over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_REPLY || cmd.op == DP_RELEASE || cmd.op == DP_DROP ||
     cmd.op == DP_GRANT) |-> (!out_valid || out_ready))
    else $error("result issued while output register is occupied");

  // The queue never grows past one slot per client.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_ENQUEUE) |-> !st.queue_full)
    else $error("enqueue into a full queue");

  // Grants only happen when the lock mode allows the head entry in.
  a_grant_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_GRANT) |-> st.can_grant)
    else $error("grant issued while the lock excludes the queue head");

  // Once a request is taken, in_ready drops, so no request is accepted in the cycle after.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while the first is still in work");

endmodule

[sv/rwlf_dpath.sv]
module rwlf_dpath import rwlf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ctl_cmd_t   cmd,
  input  logic       out_ready,
  output dp_status_t st,
  output logic       out_valid,
  output out_item_t  out_item
);

  in_item_t           req_r;
  client_t            q_client_r [CLIENTS];
  client_t            q_client_nxt [CLIENTS];
  logic [CLIENTS-1:0] q_wr_r, q_wr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic               held_w_r, held_w_nxt;
  logic [CLIENTS-1:0] pending_r, pending_nxt;
  logic [HOLD_W-1:0]  holds_r [CLIENTS];
  logic [HOLD_W-1:0]  holds_nxt [CLIENTS];
  logic [CLIENTS-1:0] match_r, match_nxt;
  logic [CLIENTS-1:0] shift_mask;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  client_t            head_client;
  client_t            hold_addr;
  logic [HOLD_W-1:0]  hold_cur;
  logic               emit;

  assign head_client = q_client_r[0];
  // One hold counter is read per cycle: the queue head while granting, else the requester.
  assign hold_addr   = cmd.run_sel ? head_client : req_r.client;
  assign hold_cur    = holds_r[hold_addr];

  always_comb begin
    st.command       = req_r.command;
    st.allowed       = req_r.allowed;
    st.in_range      = (32'(req_r.client) < CLIENTS);
    st.pending       = pending_r[req_r.client];
    st.holds_zero    = (hold_cur == '0);
    st.queue_full    = (count_r >= CNT_W'(CLIENTS));
    st.release_rerun = (total_r <= TOT_W'(1)) && (count_r != '0);
    st.can_grant     = (count_r != '0) && !((total_r != '0) && (held_w_r || q_wr_r[0]));
    st.grant_more    = (count_r > CNT_W'(1)) && !q_wr_r[0] && !q_wr_r[1];
    st.out_free      = !out_valid_r || out_ready;
  end

  // Entries at or above the aborted one move down by one.
  always_comb begin
    for (int j = 0; j < CLIENTS; j++) begin
      shift_mask[j] = 1'b0;
      for (int i = 0; i < CLIENTS; i++) begin
        if (i <= j) begin
          shift_mask[j] = shift_mask[j] | match_r[i];
        end
      end
    end
  end

  always_comb begin
    q_client_nxt = q_client_r;
    q_wr_nxt     = q_wr_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    held_w_nxt   = held_w_r;
    pending_nxt  = pending_r;
    holds_nxt    = holds_r;
    match_nxt    = match_r;
    unique case (cmd.op)
      DP_ENQUEUE: begin
        q_client_nxt[count_r[IDX_W-1:0]] = req_r.client;
        q_wr_nxt[count_r[IDX_W-1:0]]     = req_r.command[0];
        count_nxt                        = count_r + CNT_W'(1);
        pending_nxt[req_r.client]        = 1'b1;
      end
      DP_RELEASE: begin
        holds_nxt[hold_addr] = hold_cur - HOLD_W'(1);
        if (total_r != '0) begin
          total_nxt = total_r - TOT_W'(1);
        end
      end
      DP_FIND: begin
        for (int j = 0; j < CLIENTS; j++) begin
          match_nxt[j] = (CNT_W'(j) < count_r) && (q_client_r[j] == req_r.client);
        end
      end
      DP_DROP: begin
        for (int j = 0; j < CLIENTS - 1; j++) begin
          if (shift_mask[j]) begin
            q_client_nxt[j] = q_client_r[j+1];
            q_wr_nxt[j]     = q_wr_r[j+1];
          end
        end
        if (|match_r) begin
          count_nxt = count_r - CNT_W'(1);
        end
        pending_nxt[req_r.client] = 1'b0;
      end
      DP_GRANT: begin
        for (int j = 0; j < CLIENTS - 1; j++) begin
          q_client_nxt[j] = q_client_r[j+1];
          q_wr_nxt[j]     = q_wr_r[j+1];
        end
        count_nxt                = count_r - CNT_W'(1);
        pending_nxt[head_client] = 1'b0;
        if (hold_cur != '1) begin
          holds_nxt[hold_addr] = hold_cur + HOLD_W'(1);
        end
        if (total_r != '1) begin
          total_nxt = total_r + TOT_W'(1);
        end
        held_w_nxt = q_wr_r[0];
      end
      default: begin
      end
    endcase
  end

  assign emit = (cmd.op == DP_REPLY) || (cmd.op == DP_RELEASE) ||
                (cmd.op == DP_DROP) || (cmd.op == DP_GRANT);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.kind      = cmd.kind;
      out_item_nxt.target    = cmd.run_sel ? head_client : req_r.client;
      out_item_nxt.exclusive = cmd.run_sel ? q_wr_r[0] : 1'b0;
      out_item_nxt.last      = cmd.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      held_w_r    <= 1'b0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < CLIENTS; j++) begin
        holds_r[j] <= '0;
      end
    end else begin
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      held_w_r    <= held_w_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      holds_r     <= holds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      req_r <= in_item;
    end
    q_client_r <= q_client_nxt;
    q_wr_r     <= q_wr_nxt;
    match_r    <= match_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[sv/rwlf_ctrl.sv]
module rwlf_ctrl import rwlf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_RUN  = 4'b0100,
    S_DROP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = DP_NONE;
    cmd.kind    = KIND_OK;
    cmd.last    = 1'b0;
    cmd.run_sel = (state_r == S_RUN);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.out_free) begin
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
          priority if (!st.in_range) begin
            cmd.op   = DP_REPLY;
            cmd.kind = KIND_DENY;
          end else if (st.command == CMD_READ || st.command == CMD_WRITE) begin
            priority if (!st.allowed) begin
              cmd.op   = DP_REPLY;
              cmd.kind = KIND_DENY;
            end else if (st.pending || st.queue_full) begin
              cmd.op   = DP_REPLY;
              cmd.kind = KIND_BUSY;
            end else begin
              cmd.op    = DP_ENQUEUE;
              state_nxt = S_RUN;
            end
          end else if (st.command == CMD_RELEASE) begin
            if (st.holds_zero) begin
              cmd.op   = DP_REPLY;
              cmd.kind = KIND_DENY;
            end else begin
              cmd.op   = DP_RELEASE;
              cmd.last = !st.release_rerun;
              if (st.release_rerun) begin
                state_nxt = S_RUN;
              end
            end
          end else begin
            if (st.pending) begin
              cmd.op    = DP_FIND;
              cmd.last  = 1'b0;
              state_nxt = S_DROP;
            end else begin
              cmd.op = DP_REPLY;
            end
          end
        end
      end
      S_RUN: begin
        if (!st.can_grant) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.op   = DP_GRANT;
          cmd.kind = KIND_GRANT;
          cmd.last = !st.grant_more;
          if (!st.grant_more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DROP: begin
        if (st.out_free) begin
          cmd.op    = DP_DROP;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
